// ----- hw/rtl/dasc_pkg.sv -----
// dasc_pkg: shared types and constants for the direct address syntax checker.
// Character classes, parser phases, expected-token codes and the result record.
// No dependencies.
package dasc_pkg;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;

	typedef enum logic [4:0] {
		C_NUL, C_PCT, C_STAR, C_BANG, C_DOLLAR, C_QUOTE, C_PLUS, C_DOT, C_UNDER,
		C_DIGIT, C_I, C_Q, C_M, C_X, C_B, C_W, C_D, C_L, C_S, C_ALPHA, C_OTHER
	} cls_t;

	typedef enum logic [3:0] {
		PH_PCT, PH_LOC, PH_SIZE, PH_ASIZE, PH_STAR, PH_FFIRST, PH_FBEGIN,
		PH_DIGITS, PH_QUOTE, PH_IDENT, PH_FAFTER, PH_MOD, PH_SWALLOW
	} phase_t;

	typedef enum logic [2:0] {
		EXP_NONE, EXP_PCT, EXP_LOC, EXP_SEP, EXP_SIZE, EXP_FIELD
	} exp_t;

	localparam logic [1:0] LOC_NONE = 2'd0;
	localparam logic [1:0] LOC_I    = 2'd1;
	localparam logic [1:0] LOC_Q    = 2'd2;
	localparam logic [1:0] LOC_M    = 2'd3;

	localparam logic [2:0] SZ_NONE = 3'd0;
	localparam logic [2:0] SZ_X    = 3'd1;
	localparam logic [2:0] SZ_B    = 3'd2;
	localparam logic [2:0] SZ_W    = 3'd3;
	localparam logic [2:0] SZ_D    = 3'd4;
	localparam logic [2:0] SZ_L    = 3'd5;
	localparam logic [2:0] SZ_S    = 3'd6;

	typedef struct packed {
		logic       ok;
		logic [2:0] expected_code;
		logic       unterminated_quote;
		logic [7:0] stop_index;
		logic [1:0] location;
		logic [2:0] size_code;
		logic       has_star;
		logic       has_modifier;
	} res_t;

	typedef struct packed {
		logic in_valid;
		logic res_full;
	} back_stat_t;

	typedef struct packed {
		logic in_pop;
		logic res_push;
	} back_ctl_t;

endpackage

// ----- hw/rtl/direct_address_syntax_checker.sv -----
// Direct address syntax checker: takes one ASCII character per cycle on push/full
// (0 ends a string) and gives one result per string, at the end or at the first
// error, on empty/pop. Sustained rate is one character per clock while the parser
// does not stall; the grammar state machine steps once per character. A result shows
// on the outputs in the cycle after its deciding character leaves the class queue.
// Both queues hold two entries. The parser stalls on any character while two results
// wait unread; the input then shows full once the class queue fills.
// Depends on dasc_pkg, dasc_classify, dasc_fifo, dasc_parse.
module direct_address_syntax_checker
	import dasc_pkg::*;
#(
	parameter int MAX_LEN = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] ch,
	output logic       empty,
	input  logic       pop,
	output logic       ok,
	output logic [2:0] expected_code,
	output logic       unterminated_quote,
	output logic [7:0] stop_index,
	output logic [1:0] location,
	output logic [2:0] size_code,
	output logic       has_star,
	output logic       has_modifier
);

	localparam int IDXW = $clog2(MAX_LEN + 1);
	localparam int CLSW = $bits(cls_t);
	localparam int RESW = $bits(res_t);

	cls_t            cls_in;
	logic [CLSW-1:0] cls_q_data;
	logic            cls_empty;
	back_stat_t      stat;
	back_ctl_t       ctl;
	res_t            res_new, res_head;
	logic            res_full;

	dasc_classify u_classify (
		.ch  (ch),
		.cls (cls_in)
	);

	dasc_fifo #(.WIDTH(CLSW), .DEPTH(2)) u_cls_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cls_in),
		.full    (full),
		.rd_en   (ctl.in_pop),
		.rd_data (cls_q_data),
		.empty   (cls_empty)
	);

	assign stat.in_valid = !cls_empty;
	assign stat.res_full = res_full;

	dasc_parse #(.MAX_LEN(MAX_LEN), .IDXW(IDXW)) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cls    (cls_t'(cls_q_data)),
		.ctl    (ctl),
		.res    (res_new)
	);

	dasc_fifo #(.WIDTH(RESW), .DEPTH(2)) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ctl.res_push),
		.wr_data (res_new),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_head),
		.empty   (empty)
	);

	assign ok                 = res_head.ok;
	assign expected_code      = res_head.expected_code;
	assign unterminated_quote = res_head.unterminated_quote;
	assign stop_index         = res_head.stop_index;
	assign location           = res_head.location;
	assign size_code          = res_head.size_code;
	assign has_star           = res_head.has_star;
	assign has_modifier       = res_head.has_modifier;

endmodule

// ----- hw/rtl/dasc_classify.sv -----
// dasc_classify: front end, maps an ASCII character to its grammar class.
// Depends on dasc_pkg.
module dasc_classify
	import dasc_pkg::*;
(
	input  logic [7:0] ch,
	output cls_t       cls
);

	always_comb begin
		priority if (ch == CH_NUL)                 cls = C_NUL;
		else if (ch == CH_PCT)                     cls = C_PCT;
		else if (ch == CH_STAR)                    cls = C_STAR;
		else if (ch == CH_BANG)                    cls = C_BANG;
		else if (ch == CH_DOLLAR)                  cls = C_DOLLAR;
		else if (ch == CH_QUOTE)                   cls = C_QUOTE;
		else if (ch == CH_PLUS)                    cls = C_PLUS;
		else if (ch == CH_DOT)                     cls = C_DOT;
		else if (ch == CH_UNDER)                   cls = C_UNDER;
		else if (ch >= 8'h30 && ch <= 8'h39)       cls = C_DIGIT;
		else if (ch == 8'h49)                      cls = C_I;
		else if (ch == 8'h51)                      cls = C_Q;
		else if (ch == 8'h4D)                      cls = C_M;
		else if (ch == 8'h58)                      cls = C_X;
		else if (ch == 8'h42)                      cls = C_B;
		else if (ch == 8'h57)                      cls = C_W;
		else if (ch == 8'h44)                      cls = C_D;
		else if (ch == 8'h4C)                      cls = C_L;
		else if (ch == 8'h53)                      cls = C_S;
		else if ((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A)) cls = C_ALPHA;
		else                                       cls = C_OTHER;
	end

endmodule

// ----- hw/rtl/dasc_fifo.sv -----
// dasc_fifo: small register queue used between front and back and at the output.
// Standalone; no package dependency.
module dasc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(DEPTH))
		else $error("fifo count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (cnt_q == $past(cnt_q) + CW'(1)))
		else $error("fifo count did not track write");
	assert property (@(posedge clk) disable iff (!arst_n)
		(do_rd && !do_wr) |=> (cnt_q == $past(cnt_q) - CW'(1)))
		else $error("fifo count did not track read");

endmodule

// ----- hw/rtl/dasc_parse.sv -----
// dasc_parse: back end, grammar state machine over classified characters.
// Depends on dasc_pkg; fed from the class queue, writes the result queue.
module dasc_parse
	import dasc_pkg::*;
#(
	parameter int MAX_LEN = 255,
	parameter int IDXW    = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  back_stat_t stat,
	input  cls_t       cls,
	output back_ctl_t  ctl,
	output res_t       res
);

	typedef struct packed {
		phase_t ph;
		logic   emit;
		logic   ok;
		exp_t   code;
		logic   unt;
		logic   set_mod;
	} step_t;

	phase_t        phase_q;
	logic [IDXW-1:0] idx_q;
	logic [1:0]    loc_q, loc_d;
	logic [2:0]    size_q, size_d;
	logic          star_q, star_d;
	logic          mod_q;
	step_t         s;
	phase_t        phase_d;
	logic          take;
	logic [31:0]   idx_ext;

	function automatic logic is_alpha(cls_t c);
		return c == C_I || c == C_Q || c == C_M || c == C_X || c == C_B || c == C_W ||
			c == C_D || c == C_L || c == C_S || c == C_ALPHA;
	endfunction

	function automatic step_t st_stay(phase_t p);
		step_t r;
		r.ph      = p;
		r.emit    = 1'b0;
		r.ok      = 1'b0;
		r.code    = EXP_NONE;
		r.unt     = 1'b0;
		r.set_mod = 1'b0;
		return r;
	endfunction

	function automatic step_t st_emit(logic ok, exp_t code, logic unt);
		step_t r;
		r      = st_stay(PH_SWALLOW);
		r.emit = 1'b1;
		r.ok   = ok;
		r.code = code;
		r.unt  = unt;
		return r;
	endfunction

	function automatic step_t after_field(cls_t c, logic newf);
		step_t r;
		if (c == C_NUL) begin
			r = st_emit(1'b1, EXP_NONE, 1'b0);
		end else if (c == C_DOT && newf) begin
			r = st_stay(PH_FBEGIN);
		end else if (c == C_BANG) begin
			r = st_stay(PH_MOD);
			r.set_mod = 1'b1;
		end else begin
			r = st_emit(1'b0, EXP_FIELD, 1'b0);
		end
		return r;
	endfunction

	function automatic step_t field_char(cls_t c, logic first);
		step_t r;
		if (first && c == C_NUL) begin
			r = st_emit(1'b0, EXP_FIELD, 1'b0);
		end else if (c == C_DIGIT) begin
			r = st_stay(PH_DIGITS);
		end else if (c == C_QUOTE) begin
			r = st_stay(PH_QUOTE);
		end else if (is_alpha(c) || c == C_UNDER || c == C_DOLLAR) begin
			r = st_stay(PH_IDENT);
		end else begin
			r = after_field(c, 1'b0);
		end
		return r;
	endfunction

	assign take         = stat.in_valid && !stat.res_full;
	assign ctl.in_pop   = take;
	assign ctl.res_push = take && s.emit;

	always_comb begin
		s      = st_stay(phase_q);
		loc_d  = loc_q;
		size_d = size_q;
		star_d = star_q;
		unique case (phase_q)
			PH_PCT: begin
				if (cls == C_PCT) s = st_stay(PH_LOC);
				else              s = st_emit(1'b0, EXP_PCT, 1'b0);
			end
			PH_LOC: begin
				if (is_alpha(cls)) begin
					s = st_stay(PH_SIZE);
					priority if (cls == C_I) loc_d = LOC_I;
					else if (cls == C_Q)     loc_d = LOC_Q;
					else if (cls == C_M)     loc_d = LOC_M;
					else                     s = st_emit(1'b0, EXP_LOC, 1'b0);
				end else if (cls == C_STAR) begin
					star_d = 1'b1;
					s      = st_stay(PH_STAR);
				end else begin
					s = field_char(cls, 1'b1);
				end
			end
			PH_SIZE, PH_ASIZE: begin
				if (phase_q == PH_SIZE && (is_alpha(cls) || cls == C_UNDER)) begin
					s = st_stay(PH_ASIZE);
					priority if (cls == C_X) size_d = SZ_X;
					else if (cls == C_B)     size_d = SZ_B;
					else if (cls == C_W)     size_d = SZ_W;
					else if (cls == C_D)     size_d = SZ_D;
					else if (cls == C_L)     size_d = SZ_L;
					else if (cls == C_S)     size_d = SZ_S;
					else                     s = st_emit(1'b0, EXP_SIZE, 1'b0);
				end else if (cls == C_STAR) begin
					star_d = 1'b1;
					s      = st_stay(PH_STAR);
				end else begin
					s = field_char(cls, 1'b1);
				end
			end
			PH_STAR: begin
				if (cls == C_NUL)                        s = st_emit(1'b1, EXP_NONE, 1'b0);
				else if (cls == C_PLUS || cls == C_DOT)  s = st_stay(PH_FFIRST);
				else if (cls == C_BANG)                  s = field_char(cls, 1'b1);
				else                                     s = st_emit(1'b0, EXP_SEP, 1'b0);
			end
			PH_FFIRST: s = field_char(cls, 1'b1);
			PH_FBEGIN: s = field_char(cls, 1'b0);
			PH_DIGITS: begin
				if (cls != C_DIGIT) s = after_field(cls, 1'b1);
			end
			PH_QUOTE: begin
				if (cls == C_QUOTE)     s = st_stay(PH_FAFTER);
				else if (cls == C_NUL)  s = st_emit(1'b0, EXP_FIELD, 1'b1);
			end
			PH_IDENT: begin
				if (!(is_alpha(cls) || cls == C_DIGIT || cls == C_UNDER))
					s = after_field(cls, 1'b1);
			end
			PH_FAFTER: s = after_field(cls, 1'b1);
			PH_MOD: begin
				if (cls == C_NUL) s = st_emit(1'b1, EXP_NONE, 1'b0);
			end
			PH_SWALLOW: s = st_stay(PH_SWALLOW);
			default: s = st_stay(PH_SWALLOW);
		endcase
		if (s.emit) phase_d = s.ok ? PH_PCT : PH_SWALLOW;
		else        phase_d = s.ph;
	end

	assign idx_ext                = 32'(idx_q);
	assign res.ok                 = s.ok;
	assign res.expected_code      = s.code;
	assign res.unterminated_quote = s.unt;
	assign res.stop_index         = idx_ext[7:0];
	assign res.location           = loc_q;
	assign res.size_code          = size_q;
	assign res.has_star           = star_q;
	assign res.has_modifier       = mod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PCT;
			idx_q   <= '0;
			loc_q   <= LOC_NONE;
			size_q  <= SZ_NONE;
			star_q  <= 1'b0;
			mod_q   <= 1'b0;
		end else if (take) begin
			if (cls == C_NUL) begin
				phase_q <= PH_PCT;
				idx_q   <= '0;
				loc_q   <= LOC_NONE;
				size_q  <= SZ_NONE;
				star_q  <= 1'b0;
				mod_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				loc_q   <= loc_d;
				size_q  <= size_d;
				star_q  <= star_d;
				if (s.set_mod) mod_q <= 1'b1;
				if (idx_q < IDXW'(MAX_LEN)) idx_q <= idx_q + IDXW'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) idx_q <= IDXW'(MAX_LEN))
		else $error("char index past limit");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.res_push && res.ok |-> (res.expected_code == EXP_NONE && !res.unterminated_quote))
		else $error("accepted result carries an error code");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.res_push && res.unterminated_quote |-> (!res.ok && res.expected_code == EXP_FIELD))
		else $error("unterminated quote without field error");
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && cls == C_NUL) |=> (phase_q == PH_PCT && idx_q == '0))
		else $error("terminator did not restart the string");
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && s.emit && !s.ok && cls != C_NUL) |=> phase_q == PH_SWALLOW)
		else $error("error did not enter swallow");

endmodule
